// ===== rtl/phm_pkg.sv =====
// ----------------------------------------------------------------------------
// phm_pkg
// Shared constants, codes and types for the pointer-keyed hash map.
// ----------------------------------------------------------------------------
package phm_pkg;

  localparam int unsigned TABLE_ENTRIES = 4096;  // power of two
  localparam int unsigned HASH_SHIFT    = 4;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned KEY_W         = 64;
  localparam int unsigned VAL_W         = 64;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PUT   = 2'd1,
    OP_GET   = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FOUND = 3'd1,
    ST_MISS  = 3'd2,
    ST_FULL  = 3'd3,
    ST_NULL  = 3'd4
  } status_e;

  // memory access issued by the controller to both slot stores
  typedef struct packed {
    logic             key_we;
    logic             val_we;
    logic [IDX_W-1:0] addr;
    logic [KEY_W-1:0] key_wdata;
    logic [VAL_W-1:0] val_wdata;
  } mem_req_t;

  function automatic logic [IDX_W-1:0] home_slot(logic [KEY_W-1:0] key);
    return key[HASH_SHIFT +: IDX_W];
  endfunction

endpackage

// ===== rtl/pointer_keyed_hash_map_top.sv =====
// ----------------------------------------------------------------------------
// pointer_keyed_hash_map_top
// Open-addressing hash map, 64-bit keys to 64-bit values, linear probing.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its result shows
// on done_o for one cycle and cannot be held off. A put or get walks the slots
// in turn from the home slot, up to every slot of a full table; a null key or
// the unused opcode answers the next cycle without going busy. Clear visits
// every slot in turn. The single-port key memory is visited one slot per
// cycle. After reset a clearing pass over all TABLE_ENTRIES (4096) slots runs
// with busy high before the first transaction.
module pointer_keyed_hash_map_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [63:0] lookup_key_i,
  input  logic [63:0] store_value_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [63:0] found_value_o
);

  phm_pkg::mem_req_t         mem_req;
  logic [phm_pkg::KEY_W-1:0] key_rdata;
  logic [phm_pkg::VAL_W-1:0] val_rdata;

  phm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_o        (busy),
    .opcode_i      (opcode_i),
    .key_i         (lookup_key_i),
    .value_i       (store_value_i),
    .mem_req_o     (mem_req),
    .key_rdata_i   (key_rdata),
    .val_rdata_i   (val_rdata),
    .done_o        (done_o),
    .status_o      (status_o),
    .found_value_o (found_value_o)
  );

  phm_ram #(
    .WIDTH (phm_pkg::KEY_W),
    .DEPTH (phm_pkg::TABLE_ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.key_we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.key_wdata),
    .rdata_o (key_rdata)
  );

  phm_ram #(
    .WIDTH (phm_pkg::VAL_W),
    .DEPTH (phm_pkg::TABLE_ENTRIES)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.val_we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.val_wdata),
    .rdata_o (val_rdata)
  );

endmodule

// ===== rtl/phm_ram.sv =====
// ----------------------------------------------------------------------------
// phm_ram
// Single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module phm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/phm_ctrl.sv =====
// ----------------------------------------------------------------------------
// phm_ctrl
// Probe sequencer: clearing sweep, linear probe walk and result register.
// ----------------------------------------------------------------------------
module phm_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [1:0]                opcode_i,
  input  logic [phm_pkg::KEY_W-1:0] key_i,
  input  logic [phm_pkg::VAL_W-1:0] value_i,
  output phm_pkg::mem_req_t         mem_req_o,
  input  logic [phm_pkg::KEY_W-1:0] key_rdata_i,
  input  logic [phm_pkg::VAL_W-1:0] val_rdata_i,
  output logic                      done_o,
  output logic [2:0]                status_o,
  output logic [phm_pkg::VAL_W-1:0] found_value_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CLEAR = 2'd1;
  localparam logic [1:0] S_PROBE = 2'd2;

  logic [1:0]                      state_q, state_d;
  logic [phm_pkg::IDX_W-1:0]       idx_q, idx_d;
  logic [phm_pkg::IDX_W-1:0]       cnt_q, cnt_d;
  logic                            report_q, report_d;
  logic                            is_put_q, is_put_d;
  logic [phm_pkg::KEY_W-1:0]       key_q, key_d;
  logic [phm_pkg::VAL_W-1:0]       val_q, val_d;
  logic                            done_q, done_d;
  logic [2:0]                      status_q, status_d;
  logic [phm_pkg::VAL_W-1:0]       found_q, found_d;
  logic [phm_pkg::IDX_W-1:0]       idx_inc;
  logic                            slot_empty, slot_match;

  assign idx_inc    = phm_pkg::IDX_W'(idx_q + 1'b1);
  assign slot_empty = (key_rdata_i == '0);
  assign slot_match = (key_rdata_i == key_q);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    report_d  = report_q;
    is_put_d  = is_put_q;
    key_d     = key_q;
    val_d     = val_q;
    done_d    = 1'b0;
    status_d  = phm_pkg::ST_OK;
    found_d   = '0;
    mem_req_o = '{key_we: 1'b0, val_we: 1'b0, addr: idx_q,
                  key_wdata: key_q, val_wdata: val_q};

    unique case (state_q)
      S_IDLE: begin
        // read the home slot while the transaction is taken
        mem_req_o.addr = phm_pkg::home_slot(key_i);
        if (start_i) begin
          case (opcode_i) inside
            phm_pkg::OP_CLEAR: begin
              state_d  = S_CLEAR;
              idx_d    = '0;
              report_d = 1'b1;
            end
            phm_pkg::OP_PUT, phm_pkg::OP_GET: begin
              if (key_i == '0) begin
                done_d   = 1'b1;
                status_d = phm_pkg::ST_NULL;
              end else begin
                state_d  = S_PROBE;
                idx_d    = phm_pkg::home_slot(key_i);
                cnt_d    = '0;
                is_put_d = (opcode_i == phm_pkg::OP_PUT);
                key_d    = key_i;
                val_d    = value_i;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_CLEAR: begin
        mem_req_o.key_we    = 1'b1;
        mem_req_o.key_wdata = '0;
        idx_d               = idx_inc;
        if (idx_q == phm_pkg::LAST_IDX) begin
          state_d = S_IDLE;
          done_d  = report_q;
        end
      end
      S_PROBE: begin
        if (is_put_q && (slot_empty || slot_match)) begin
          mem_req_o.key_we = 1'b1;
          mem_req_o.val_we = 1'b1;
          state_d          = S_IDLE;
          done_d           = 1'b1;
        end else if (!is_put_q && slot_match) begin
          state_d  = S_IDLE;
          done_d   = 1'b1;
          status_d = phm_pkg::ST_FOUND;
          found_d  = val_rdata_i;
        end else if (!is_put_q && slot_empty) begin
          state_d  = S_IDLE;
          done_d   = 1'b1;
          status_d = phm_pkg::ST_MISS;
        end else if (cnt_q == phm_pkg::LAST_IDX) begin
          // whole table visited without a usable slot
          state_d  = S_IDLE;
          done_d   = 1'b1;
          status_d = is_put_q ? phm_pkg::ST_FULL : phm_pkg::ST_MISS;
        end else begin
          mem_req_o.addr = idx_inc;
          idx_d          = idx_inc;
          cnt_d          = phm_pkg::IDX_W'(cnt_q + 1'b1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;  // power-up sweep empties the key store
      idx_q    <= '0;
      cnt_q    <= '0;
      report_q <= 1'b0;
      is_put_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      report_q <= report_d;
      is_put_q <= is_put_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    val_q    <= val_d;
    status_q <= status_d;
    found_q  <= found_d;
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_value_o = found_q;

endmodule

// ===== rtl/phm_checker.sv =====
// ----------------------------------------------------------------------------
// phm_checker
// Port-level checks on transaction flow and result encoding.
// ----------------------------------------------------------------------------
module phm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  opcode_i,
  input logic [63:0] lookup_key_i,
  input logic [63:0] store_value_i,
  input logic        done_o,
  input logic [2:0]  status_o,
  input logic [63:0] found_value_o
);

  logic take, keyed_op;

  assign take     = start && !busy;
  assign keyed_op = (opcode_i == phm_pkg::OP_PUT) || (opcode_i == phm_pkg::OP_GET);

  // null key answers next cycle
  a_null_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && keyed_op && (lookup_key_i == '0) |=> done_o && (status_o == phm_pkg::ST_NULL))
    else $error("null key not answered next cycle");

  // a real probe goes busy and has no result yet
  a_probe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && keyed_op && (lookup_key_i != '0) |=> busy && !done_o)
    else $error("probe did not go busy");

  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (opcode_i == phm_pkg::OP_CLEAR) |=> busy && !done_o)
    else $error("clear did not start a sweep");

  // a result always leaves the block ready for the next transaction
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != phm_pkg::ST_FOUND) |-> (found_value_o == '0))
    else $error("nonzero value without a hit");

endmodule

bind pointer_keyed_hash_map_top phm_checker u_phm_checker (.*);
